/* rtl/dtss_pkg.sv */
// shared constants, codes and controller/datapath interface types
package dtss_pkg;

    localparam int MAX_CLIENTS = 15;
    localparam int TABLE_DEPTH = MAX_CLIENTS + 1;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // command codes of an input item
    typedef enum logic [1:0] {
        CMD_CONSUME  = 2'd0,
        CMD_SCHEDULE = 2'd1,
        CMD_INIT     = 2'd2,
        CMD_FINISH   = 2'd3
    } t_cmd;

    // result codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_CONTINUE = 2'd1,
        ST_DELAY    = 2'd2,
        ST_ERROR    = 2'd3
    } t_status;

    // controller commands to the datapath
    typedef struct packed {
        logic       load;
        logic       exec;
        logic       mul;
        logic [1:0] step;
        logic       acc;
        logic       cmp;
        logic       deliver;
    } t_ctrl_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic needs_test;
    } t_dp_status;

endpackage

/* rtl/dtss_ctrl.sv */
// sequencing state machine and output valid for the scheduler
module dtss_ctrl
    import dtss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_dp,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_MUL     = 6'b000100,
        S_ACC     = 6'b001000,
        S_CMP     = 6'b010000,
        S_DELIVER = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_step     = 2'd0;
                n_state    = i_dp.needs_test ? S_MUL : S_DELIVER;
            end
            S_MUL: begin
                o_cmd.mul  = 1'b1;
                o_cmd.step = r_step;
                n_step     = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_DELIVER;
            end
            S_DELIVER: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.deliver = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register valid: set on delivery, cleared when taken
    always_comb begin
        n_out_valid = o_cmd.deliver ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.deliver |-> (!r_out_valid || !i_stall))
        else $error("result loaded over a waiting item");

    // an accepted item is executed in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    // four multiply steps then accumulate
    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_step == 2'd3) |=> (r_state == S_ACC))
        else $error("multiply sequence length wrong");

    // comparison is always followed by the delivery state
    a_cmp_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_DELIVER))
        else $error("compare not followed by delivery");

endmodule

/* rtl/dtss_datapath.sv */
// client tables, update logic, shared multiplier and share comparison
module dtss_datapath
    import dtss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl_cmd   i_cmd,
    input  logic [1:0]  i_item_cmd,
    input  logic [7:0]  i_client_id,
    input  logic [31:0] i_amount,
    input  logic [47:0] i_period_now,
    input  logic [15:0] i_weight,
    output t_dp_status  o_dp,
    output logic [1:0]  o_status
);

    // tables, entry 0 holds the totals
    logic [63:0] r_used [TABLE_DEPTH];
    logic [31:0] r_wgt  [TABLE_DEPTH];
    logic [63:0] r_last [TABLE_DEPTH];

    // latched item
    t_cmd        r_cmd;
    logic [7:0]  r_id;
    logic [31:0] r_amount;
    logic [47:0] r_period;
    logic [15:0] r_weight;

    // test operands, product and accumulators
    logic [63:0] r_opa, r_opc;
    logic [31:0] r_opb, r_opd;
    logic [63:0] r_prod;
    logic [95:0] r_acc_l, r_acc_r;
    t_status     r_status;
    t_status     r_out_status;

    logic             present, is_zero, new_period;
    logic [IDX_W-1:0] idx;
    logic [63:0]      ut_c, lp_c, ut_t, lp_t, amt64;
    logic [31:0]      sw_c, sw_t, w32;
    logic [63:0]      cl_ut_n, cl_lp_n, tot_ut_n, tot_lp_n;
    logic [31:0]      cl_sw_n, tot_sw_n;
    logic             cl_we, tot_lp_we;
    t_status          ex_status;
    logic [31:0]      mul_a, mul_b;
    logic             acc_en;
    logic [1:0]       acc_sel;

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= t_cmd'(i_item_cmd);
            r_id     <= i_client_id;
            r_amount <= i_amount;
            r_period <= i_period_now;
            r_weight <= i_weight;
        end
    end

    // entry lookup
    assign present = (r_id <= 8'(MAX_CLIENTS));
    assign is_zero = (r_id == 8'd0);
    assign idx     = r_id[IDX_W-1:0];
    assign ut_c    = r_used[idx];
    assign sw_c    = r_wgt[idx];
    assign lp_c    = r_last[idx];
    assign ut_t    = r_used[0];
    assign sw_t    = r_wgt[0];
    assign lp_t    = r_last[0];
    assign amt64   = {32'd0, r_amount};
    assign w32     = {16'd0, r_weight};
    assign new_period = (lp_c != {16'd0, r_period});

    assign o_dp.needs_test = (r_cmd == CMD_SCHEDULE) && present;

    // table update for the latched item; entry 0 as client handled apart
    always_comb begin
        cl_we     = 1'b0;
        cl_ut_n   = ut_c;
        cl_sw_n   = sw_c;
        cl_lp_n   = lp_c;
        tot_ut_n  = ut_t;
        tot_sw_n  = sw_t;
        tot_lp_we = 1'b0;
        tot_lp_n  = lp_t;
        ex_status = ST_DONE;
        unique case (r_cmd)
            CMD_CONSUME: begin
                if (is_zero) begin
                    tot_ut_n = ut_t + {31'd0, r_amount, 1'b0};
                end else begin
                    tot_ut_n = ut_t + amt64;
                    if (present) begin
                        cl_we   = 1'b1;
                        cl_ut_n = ut_c + amt64;
                    end
                end
                ex_status = ST_DONE;
            end
            CMD_SCHEDULE: begin
                if (present && new_period) begin
                    if (is_zero) begin
                        tot_ut_n  = 64'd0;
                        tot_lp_we = 1'b1;
                        tot_lp_n  = {16'd0, r_period};
                    end else begin
                        cl_we    = 1'b1;
                        cl_lp_n  = {16'd0, r_period};
                        cl_ut_n  = 64'd0;
                        tot_ut_n = ut_t - ut_c;
                    end
                end
                ex_status = ST_DELAY;
            end
            CMD_INIT: begin
                if (present) begin
                    if (is_zero) begin
                        tot_ut_n  = 64'd0;
                        tot_lp_we = 1'b1;
                        tot_lp_n  = 64'd0;
                        if (r_weight != 16'd0) begin
                            tot_sw_n = {15'd0, r_weight, 1'b0};
                        end
                    end else begin
                        cl_we   = 1'b1;
                        cl_ut_n = 64'd0;
                        cl_lp_n = 64'd0;
                        if (r_weight != 16'd0) begin
                            cl_sw_n  = w32;
                            tot_sw_n = sw_t + w32;
                        end
                    end
                    ex_status = (r_weight != 16'd0) ? ST_DONE : ST_ERROR;
                end else begin
                    ex_status = ST_ERROR;
                end
            end
            CMD_FINISH: begin
                if (present) begin
                    if (is_zero) begin
                        tot_ut_n = 64'd0;
                        tot_sw_n = 32'd0;
                    end else begin
                        cl_we    = 1'b1;
                        cl_ut_n  = 64'd0;
                        cl_sw_n  = 32'd0;
                        tot_ut_n = ut_t - ut_c;
                        tot_sw_n = sw_t - sw_c;
                    end
                end
                ex_status = ST_DONE;
            end
            default: begin
                ex_status = ST_DONE;
            end
        endcase
    end

    // table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_used[i] <= 64'd0;
                r_wgt[i]  <= 32'd0;
                r_last[i] <= 64'd0;
            end
        end else if (i_cmd.exec) begin
            if (cl_we) begin
                r_used[idx] <= cl_ut_n;
                r_wgt[idx]  <= cl_sw_n;
                r_last[idx] <= cl_lp_n;
            end
            r_used[0] <= tot_ut_n;
            r_wgt[0]  <= tot_sw_n;
            if (tot_lp_we) begin
                r_last[0] <= tot_lp_n;
            end
        end
    end

    // multiplier operand halves per step
    always_comb begin
        unique case (i_cmd.step)
            2'd0: begin mul_a = r_opa[31:0];  mul_b = r_opb; end
            2'd1: begin mul_a = r_opa[63:32]; mul_b = r_opb; end
            2'd2: begin mul_a = r_opc[31:0];  mul_b = r_opd; end
            default: begin mul_a = r_opc[63:32]; mul_b = r_opd; end
        endcase
    end

    // each product is added in the cycle after it is formed
    assign acc_en  = (i_cmd.mul && (i_cmd.step != 2'd0)) || i_cmd.acc;
    assign acc_sel = i_cmd.acc ? 2'd3 : (i_cmd.step - 2'd1);

    // operands, product, accumulators and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_opa    <= is_zero ? tot_ut_n : cl_ut_n;
            r_opb    <= tot_sw_n;
            r_opc    <= tot_ut_n;
            r_opd    <= is_zero ? tot_sw_n : cl_sw_n;
            r_status <= ex_status;
        end
        if (i_cmd.mul) begin
            r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
        end
        if (acc_en) begin
            unique case (acc_sel)
                2'd0:    r_acc_l <= {32'd0, r_prod};
                2'd1:    r_acc_l <= r_acc_l + {r_prod, 32'd0};
                2'd2:    r_acc_r <= {32'd0, r_prod};
                default: r_acc_r <= r_acc_r + {r_prod, 32'd0};
            endcase
        end
        if (i_cmd.cmp) begin
            r_status <= (r_acc_l <= r_acc_r) ? ST_CONTINUE : ST_DELAY;
        end
        if (i_cmd.deliver) begin
            r_out_status <= r_status;
        end
    end

    assign o_status = r_out_status;

endmodule

/* rtl/device_time_share_scheduler.sv */
// top level of the device time share scheduler
//
//  channel  | direction | handshake          | payload
//  request  | in        | i_valid / o_stall  | i_cmd, i_client_id, i_amount,
//           |           |                    | i_period_now, i_weight
//  result   | out       | o_valid / i_stall  | o_status
//
// consume, init, finish and schedule of a missing client pass through these steps:
// accept, table update, result load
// schedule of a present client passes through: accept, table update, four steps of the
// 64x32 share products on one 32x32 multiplier, accumulate, 96-bit compare, result load
// one item at a time; the result register lets a new item enter while a result waits
// synchronous active-low reset clears all tables to zero
// a stalled result holds the next item in the delivery state until the register frees
module device_time_share_scheduler
    import dtss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_client_id,
    input  logic [31:0] i_amount,
    input  logic [47:0] i_period_now,
    input  logic [15:0] i_weight,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // sequencing
    dtss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_dp    (dp_status),
        .o_cmd   (ctrl_cmd)
    );

    // tables and arithmetic
    dtss_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctrl_cmd),
        .i_item_cmd   (i_cmd),
        .i_client_id  (i_client_id),
        .i_amount     (i_amount),
        .i_period_now (i_period_now),
        .i_weight     (i_weight),
        .o_dp         (dp_status),
        .o_status     (o_status)
    );

endmodule
